>>> rtl/pwm_audio_sample_fifo_player_core_macros.svh
// Assertion macros for the player core RTL.
`ifndef PWM_AUDIO_SAMPLE_FIFO_PLAYER_CORE_MACROS_SVH
`define PWM_AUDIO_SAMPLE_FIFO_PLAYER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define PASFP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PASFP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PASFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PASFP_ASSERT(lbl, cond, msg)
`define PASFP_ASSERT_IMPL(lbl, ante, cons, msg)
`define PASFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/pasfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pasfp_pkg;

    localparam int RING_DEPTH_DEF    = 512;
    localparam int MAX_DUTY_BITS_DEF = 14;
    localparam int DUTY_W            = 14;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 20;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;

    localparam logic [1:0] WS_OK    = 2'd0;
    localparam logic [1:0] WS_DROP  = 2'd1;
    localparam logic [1:0] WS_RETRY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEREO       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_FREQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_RES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_WORDS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS  = 3'd5;

    localparam logic [19:0] SAMPLE_RATE_RST  = 20'd48000;
    localparam logic [19:0] CARRIER_FREQ_RST = 20'd48000;
    localparam logic [3:0]  DUTY_RES_RST     = 4'd10;
    localparam logic [9:0]  RING_WORDS_RST   = 10'd512;
    localparam logic [9:0]  BLOCK_WORDS_RST  = 10'd64;

    localparam logic [31:0] SILENCE_WORD = 32'h8000_8000;
    localparam logic [15:0] SIGN_FLIP    = 16'h8000;
    localparam logic [20:0] ACC_MAX      = 21'h1F_FFFF;
    localparam logic [9:0]  BLOCK_MAX    = 10'd512;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] sample;
        logic               wait_if_full;
    } req_t;

    typedef struct packed {
        logic [1:0]        write_status;
        logic              duty_update;
        logic [DUTY_W-1:0] duty_left;
        logic [DUTY_W-1:0] duty_right;
        logic              underflow_now;
        logic              block_done;
        logic              underflow_flag;
        logic [10:0]       free_bytes;
    } rsp_t;

    typedef struct packed {
        logic        stereo;
        logic [19:0] sample_rate;
        logic [19:0] carrier_freq;
        logic [3:0]  duty_bits;
        logic [9:0]  ring_words;
        logic [9:0]  block_words;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/pasfp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pasfp_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [pasfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pasfp_pkg::CFG_DATA_W-1:0] cfg_data,
    output pasfp_pkg::cfg_t                      cfg,
    output logic                                 ring_clear
);
    import pasfp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_STEREO:       cfg_next.stereo       = cfg_data[0];
                CFG_SAMPLE_RATE:  cfg_next.sample_rate  = cfg_data[19:0];
                CFG_CARRIER_FREQ: cfg_next.carrier_freq = cfg_data[19:0];
                CFG_DUTY_RES:     cfg_next.duty_bits    = cfg_data[3:0];
                CFG_RING_WORDS:   cfg_next.ring_words   = cfg_data[9:0];
                CFG_BLOCK_WORDS:  cfg_next.block_words  = cfg_data[9:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stereo       <= 1'b0;
            cfg_reg.sample_rate  <= SAMPLE_RATE_RST;
            cfg_reg.carrier_freq <= CARRIER_FREQ_RST;
            cfg_reg.duty_bits    <= DUTY_RES_RST;
            cfg_reg.ring_words   <= RING_WORDS_RST;
            cfg_reg.block_words  <= BLOCK_WORDS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg        = cfg_reg;
    assign ring_clear = cfg_write && (cfg_index == CFG_RING_WORDS);

endmodule

`default_nettype wire

>>> rtl/pasfp_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module pasfp_ring #(
    parameter int RING_DEPTH = pasfp_pkg::RING_DEPTH_DEF,
    localparam int IDX_W     = $clog2(RING_DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [31:0]      wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic [31:0]           rd_word
);
    logic [31:0] mem [RING_DEPTH];
    logic [31:0] rd_data_reg;
    logic [31:0] byp_data_reg;
    logic        byp_hit_reg;
    logic        byp_hit_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // forward a write that lands on the address being fetched
    assign byp_hit_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= byp_hit_next;
        end
    end

    assign rd_word = byp_hit_reg ? byp_data_reg : rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/pasfp_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module pasfp_scale #(
    parameter int MAX_DUTY_BITS = pasfp_pkg::MAX_DUTY_BITS_DEF
) (
    input  wire logic [31:0]                  word,
    input  wire logic [3:0]                   duty_bits,
    output logic [pasfp_pkg::DUTY_W-1:0]      duty_left,
    output logic [pasfp_pkg::DUTY_W-1:0]      duty_right
);
    import pasfp_pkg::*;

    localparam int PROD_W = 16 + MAX_DUTY_BITS;

    logic [4:0]               bits_sat;
    logic [MAX_DUTY_BITS:0]   full_w;
    logic [MAX_DUTY_BITS-1:0] full;
    logic [PROD_W-1:0]        prod_l;
    logic [PROD_W-1:0]        prod_r;
    logic [31:0]              shift_l;
    logic [31:0]              shift_r;

    always_comb
    begin
        bits_sat = ({1'b0, duty_bits} > 5'(MAX_DUTY_BITS)) ?
                   5'(MAX_DUTY_BITS) : {1'b0, duty_bits};
        full_w   = ({{MAX_DUTY_BITS{1'b0}}, 1'b1} << bits_sat) - 1'b1;
        full     = full_w[MAX_DUTY_BITS-1:0];
        prod_l   = PROD_W'(word[15:0]) * PROD_W'(full);
        prod_r   = PROD_W'(word[31:16]) * PROD_W'(full);
        shift_l  = 32'(prod_l >> 16);
        shift_r  = 32'(prod_r >> 16);
    end

    assign duty_left  = shift_l[DUTY_W-1:0];
    assign duty_right = shift_r[DUTY_W-1:0];

endmodule

`default_nettype wire

>>> rtl/pwm_audio_sample_fifo_player_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pwm_audio_sample_fifo_player_core_macros.svh"
// Channel   Handshake             Payload
// req       req_valid/req_stall   req   (mode, sample, wait_if_full)
// rsp       rsp_valid/rsp_stall   rsp   (status, duties, flags, free_bytes)
// cfg       cfg_write             cfg_index, cfg_data
//
// One item per cycle unless rsp_stall holds a result: an item is registered
// on accept and its result is registered into rsp as the item advances.
// The ring is read ahead into a register at the next read index, with a write
// to that entry forwarded, so a pop never waits on the ring read.
// Reset clears control state only; a ring_words write empties the ring.
// A stalled result holds both registers and raises req_stall while an item waits.

module pwm_audio_sample_fifo_player_core #(
    parameter int RING_DEPTH    = pasfp_pkg::RING_DEPTH_DEF,
    parameter int MAX_DUTY_BITS = pasfp_pkg::MAX_DUTY_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire pasfp_pkg::req_t                  req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output pasfp_pkg::rsp_t                       rsp,
    input  wire logic                             cfg_write,
    input  wire logic [pasfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pasfp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pasfp_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int SZ_W  = IDX_W + 1;
    localparam int CMP_W = (SZ_W > 10) ? SZ_W : 10;

    cfg_t cfg;
    logic ring_clear;

    req_t req_reg;
    logic item_valid_reg;
    logic item_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic accept;
    logic advance;

    logic [IDX_W-1:0] read_index_reg;
    logic [IDX_W-1:0] read_index_next;
    logic [IDX_W-1:0] write_index_reg;
    logic [IDX_W-1:0] write_index_next;
    logic [20:0]      acc_reg;
    logic [20:0]      acc_next;
    logic [8:0]       consumed_reg;
    logic [8:0]       consumed_next;
    logic             sticky_reg;
    logic             sticky_next;
    logic [15:0]      held_left_reg;
    logic [15:0]      held_left_next;
    logic             holding_reg;
    logic             holding_next;

    logic [CMP_W-1:0] rw_ext;
    logic [SZ_W-1:0]  ring_size;
    logic [SZ_W-1:0]  w_inc;
    logic [IDX_W-1:0] w_wrap;
    logic [SZ_W-1:0]  r_inc;
    logic [IDX_W-1:0] r_wrap;
    logic             ring_full;
    logic             ring_empty;
    logic [15:0]      s_u;
    logic [31:0]      push_data;
    logic             push_try;
    logic             push_en;
    logic [21:0]      acc_sum;
    logic [20:0]      acc_sat;
    logic             pop_evt;
    logic [31:0]      ring_word;
    logic [31:0]      play_word;
    logic [9:0]       blk;
    logic [9:0]       cnt_inc;
    logic [DUTY_W-1:0] duty_l;
    logic [DUTY_W-1:0] duty_r;
    logic [SZ_W-1:0]  used;
    logic [SZ_W-1:0]  free_w;
    logic [31:0]      free_b;

    pasfp_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .ring_clear (ring_clear)
    );

    pasfp_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push_en),
        .wr_addr (write_index_reg),
        .wr_data (push_data),
        .rd_addr (read_index_next),
        .rd_word (ring_word)
    );

    pasfp_scale #(.MAX_DUTY_BITS(MAX_DUTY_BITS)) u_scale (
        .word       (play_word),
        .duty_bits  (cfg.duty_bits),
        .duty_left  (duty_l),
        .duty_right (duty_r)
    );

    assign advance   = item_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = item_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        rw_ext = CMP_W'(cfg.ring_words);
        if (rw_ext < CMP_W'(2))
        begin
            ring_size = SZ_W'(2);
        end
        else if (rw_ext > CMP_W'(RING_DEPTH))
        begin
            ring_size = SZ_W'(RING_DEPTH);
        end
        else
        begin
            ring_size = SZ_W'(rw_ext);
        end

        w_inc  = SZ_W'(write_index_reg) + 1'b1;
        w_wrap = (w_inc >= ring_size) ? '0 : w_inc[IDX_W-1:0];
        r_inc  = SZ_W'(read_index_reg) + 1'b1;
        r_wrap = (r_inc >= ring_size) ? '0 : r_inc[IDX_W-1:0];
        ring_full  = (w_wrap == read_index_reg);
        ring_empty = (read_index_reg == write_index_reg);

        s_u       = req_reg.sample ^ SIGN_FLIP;
        push_data = cfg.stereo ? {s_u, held_left_reg} : {s_u, s_u};
        push_try  = advance && (req_reg.mode == MODE_WRITE) && (!cfg.stereo || holding_reg);
        push_en   = push_try && !ring_full;

        acc_sum = {1'b0, acc_reg} + 22'(cfg.sample_rate);
        acc_sat = acc_sum[21] ? ACC_MAX : acc_sum[20:0];
        pop_evt = acc_sat >= 21'(cfg.carrier_freq);
        play_word = ring_empty ? SILENCE_WORD : ring_word;

        blk = (cfg.block_words == 10'd0) ? 10'd1 :
              (cfg.block_words > BLOCK_MAX) ? BLOCK_MAX : cfg.block_words;
        cnt_inc = 10'(consumed_reg) + 10'd1;

        read_index_next  = read_index_reg;
        write_index_next = write_index_reg;
        acc_next         = acc_reg;
        consumed_next    = consumed_reg;
        sticky_next      = sticky_reg;
        held_left_next   = held_left_reg;
        holding_next     = holding_reg;
        rsp_next         = '0;

        if (advance)
        begin
            case (req_reg.mode)
                MODE_WRITE:
                begin
                    if (push_try)
                    begin
                        if (ring_full)
                        begin
                            rsp_next.write_status = req_reg.wait_if_full ? WS_RETRY : WS_DROP;
                        end
                        else
                        begin
                            write_index_next = w_wrap;
                            if (cfg.stereo)
                            begin
                                holding_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        held_left_next = s_u;
                        holding_next   = 1'b1;
                    end
                end
                MODE_TICK:
                begin
                    acc_next = acc_sat;
                    if (pop_evt)
                    begin
                        acc_next = acc_sat - 21'(cfg.carrier_freq);
                        if (ring_empty)
                        begin
                            sticky_next            = 1'b1;
                            rsp_next.underflow_now = 1'b1;
                        end
                        else
                        begin
                            read_index_next = r_wrap;
                        end
                        rsp_next.duty_update = 1'b1;
                        rsp_next.duty_left   = duty_l;
                        rsp_next.duty_right  = duty_r;
                        if (cnt_inc >= blk)
                        begin
                            consumed_next       = '0;
                            rsp_next.block_done = 1'b1;
                        end
                        else
                        begin
                            consumed_next = cnt_inc[8:0];
                        end
                    end
                end
                MODE_STATUS:
                begin
                    rsp_next.underflow_flag = sticky_reg;
                    sticky_next             = 1'b0;
                end
                default:
                begin
                    rsp_next.write_status = WS_OK;
                end
            endcase
        end

        if (ring_clear)
        begin
            read_index_next  = '0;
            write_index_next = '0;
        end

        used = (write_index_next >= read_index_next) ?
               SZ_W'(write_index_next) - SZ_W'(read_index_next) :
               SZ_W'(write_index_next) + ring_size - SZ_W'(read_index_next);
        free_w = ring_size - 1'b1 - used;
        free_b = 32'(free_w) << 2;
        rsp_next.free_bytes = free_b[10:0];

        item_valid_next = accept ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
        rsp_valid_next  = advance ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            read_index_reg  <= '0;
            write_index_reg <= '0;
            acc_reg         <= '0;
            consumed_reg    <= '0;
            sticky_reg      <= 1'b0;
            held_left_reg   <= '0;
            holding_reg     <= 1'b0;
        end
        else
        begin
            item_valid_reg  <= item_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            read_index_reg  <= read_index_next;
            write_index_reg <= write_index_next;
            acc_reg         <= acc_next;
            consumed_reg    <= consumed_next;
            sticky_reg      <= sticky_next;
            held_left_reg   <= held_left_next;
            holding_reg     <= holding_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PASFP_ASSERT(a_idx_in_ring,
        (SZ_W'(read_index_reg) < ring_size) && (SZ_W'(write_index_reg) < ring_size),
        "ring index beyond ring size")
    `PASFP_ASSERT_IMPL(a_stall_blocks,
        item_valid_reg && rsp_valid_reg && rsp_stall, req_stall && !advance,
        "item advanced into a stalled result")
    `PASFP_ASSERT_NEXT(a_advance_result,
        advance, rsp_valid_reg,
        "advanced item produced no result")
    `PASFP_ASSERT_IMPL(a_underflow_update,
        rsp_valid_reg && rsp_reg.underflow_now,
        rsp_reg.duty_update && (rsp_reg.write_status == WS_OK),
        "underflow without duty update")

endmodule

`default_nettype wire
